[rtl/assert_macros.svh]
// Assertion macros shared by the relocation table RTL.
// No dependencies; included by the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ART_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("relocation table check failed");

// Next-cycle implication, disabled during reset.
`define ART_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("relocation table check failed");

`endif

[rtl/art_pkg.sv]
// Shared types and codes for the address relocation table.
// Used by art_ctrl, art_dp and address_relocation_table_core.
package art_pkg;

   typedef logic [2:0] action_type;
   typedef logic [1:0] status_type;

   localparam action_type ACT_APPEND    = 3'd0;
   localparam action_type ACT_EXACT_NEW = 3'd1;
   localparam action_type ACT_EXACT_ORG = 3'd2;
   localparam action_type ACT_RANGE_O2N = 3'd3;
   localparam action_type ACT_RANGE_N2O = 3'd4;
   localparam action_type ACT_RANGE_O2O = 3'd5;

   localparam status_type STAT_OK       = 2'd0;
   localparam status_type STAT_MISS     = 2'd1;
   localparam status_type STAT_OVERFLOW = 2'd2;

   localparam int ADDR_W = 32;
   localparam logic [7:0] OFFSET_RESET = 8'd8;

   typedef enum logic [1:0] {
      STATE_IDLE,
      STATE_SCAN,
      STATE_PUBLISH
   } art_state_type;

   // controller to datapath
   typedef struct packed {
      logic load;     // capture request, perform append
      logic scan;     // issue table reads
      logic publish;  // move result into the output register
   } art_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_lookup;  // request on the input is an exact or range lookup
      logic scan_done;
      logic out_free;
   } art_stat_type;

endpackage

[rtl/art_dp.sv]
// Datapath of the relocation table: entry memories, scan compare, output register.
// Depends on art_pkg and assert_macros.svh.
`include "assert_macros.svh"

module art_dp #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  art_pkg::art_cmd_type cmd,
   output art_pkg::art_stat_type stat,
   input  logic [95:0]         req_tdata,
   input  logic [2:0]          req_tuser,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [31:0]         rsp_tdata,
   output logic [1:0]          rsp_tuser,
   input  logic                csr_wr_en,
   input  logic [7:0]          csr_wr_data
);
   import art_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   logic [ADDR_W-1:0] old_mem [TABLE_DEPTH];
   logic [ADDR_W-1:0] new_mem [TABLE_DEPTH];

   action_type        req_action;
   logic [ADDR_W-1:0] req_old, req_new, req_query;

   logic [7:0]        offset_ff;
   logic [CW-1:0]     count_ff, count_in;
   action_type        act_ff;
   logic [ADDR_W-1:0] query_ff;
   logic [CW-1:0]     issue_ff, issue_in;
   logic              dv_ff, dv_in;
   logic              pv_ff, pv_in;
   logic [ADDR_W-1:0] rd_old_ff, rd_new_ff;
   logic [ADDR_W-1:0] prev_old_ff, prev_new_ff;
   logic              found_ff, found_in;
   logic [ADDR_W-1:0] res_ff, res_in;
   status_type        st_ff, st_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] rsp_addr_ff;
   status_type        rsp_st_ff;

   logic              do_append, do_read, is_exact, n2o;
   logic [ADDR_W-1:0] cur_key, prev_key;
   logic              exact_hit, range_hit;

   assign req_action = req_tuser;
   assign req_old    = req_tdata[31:0];
   assign req_new    = req_tdata[63:32];
   assign req_query  = req_tdata[95:64];

   assign do_append = cmd.load && (req_action == ACT_APPEND) && (count_ff != DEPTH_C);
   assign do_read   = cmd.scan && !found_ff && (issue_ff != count_ff);

   assign is_exact = (act_ff == ACT_EXACT_NEW) || (act_ff == ACT_EXACT_ORG);
   assign n2o      = (act_ff == ACT_RANGE_N2O);
   assign cur_key  = n2o ? rd_new_ff : rd_old_ff;
   assign prev_key = n2o ? prev_new_ff : prev_old_ff;

   assign exact_hit = is_exact && (rd_old_ff == query_ff);
   assign range_hit = !is_exact && pv_ff && (query_ff >= prev_key) && (query_ff < cur_key);

   always_comb begin
      stat.is_lookup = req_action inside {ACT_EXACT_NEW, ACT_EXACT_ORG, ACT_RANGE_O2N,
                                          ACT_RANGE_N2O, ACT_RANGE_O2O};
      stat.scan_done = found_ff || ((issue_ff == count_ff) && !dv_ff);
      stat.out_free  = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      count_in     = do_append ? count_ff + CW'(1) : count_ff;
      issue_in     = do_read ? issue_ff + CW'(1) : issue_ff;
      dv_in        = do_read;
      pv_in        = pv_ff;
      found_in     = found_ff;
      res_in       = res_ff;
      st_in        = st_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) begin
         issue_in = '0;
         dv_in    = 1'b0;
         pv_in    = 1'b0;
         found_in = 1'b0;
         res_in   = '0;
         if (req_action == ACT_APPEND) begin
            st_in = (count_ff == DEPTH_C) ? STAT_OVERFLOW : STAT_OK;
         end else begin
            st_in = STAT_MISS;
         end
      end else if (dv_ff && !found_ff) begin
         pv_in = 1'b1;
         if (exact_hit) begin
            found_in = 1'b1;
            st_in    = STAT_OK;
            res_in   = (act_ff == ACT_EXACT_ORG) ? rd_new_ff + ADDR_W'(offset_ff) : rd_new_ff;
         end else if (range_hit) begin
            found_in = 1'b1;
            st_in    = STAT_OK;
            res_in   = (act_ff == ACT_RANGE_O2N) ? prev_new_ff : prev_old_ff;
         end
      end
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff    <= OFFSET_RESET;
         count_ff     <= '0;
         issue_ff     <= '0;
         dv_ff        <= 1'b0;
         pv_ff        <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            offset_ff <= csr_wr_data;
         end
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         dv_ff        <= dv_in;
         pv_ff        <= pv_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff   <= req_action;
         query_ff <= req_query;
      end
      res_ff <= res_in;
      st_ff  <= st_in;
      if (dv_ff) begin
         prev_old_ff <= rd_old_ff;
         prev_new_ff <= rd_new_ff;
      end
      if (cmd.publish) begin
         rsp_addr_ff <= res_ff;
         rsp_st_ff   <= st_ff;
      end
   end

   // entry memories: one write port, one registered read port each
   always_ff @(posedge clock) begin
      if (do_append) begin
         old_mem[count_ff[AW-1:0]] <= req_old;
         new_mem[count_ff[AW-1:0]] <= req_new;
      end
      rd_old_ff <= old_mem[issue_ff[AW-1:0]];
      rd_new_ff <= new_mem[issue_ff[AW-1:0]];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_addr_ff;
   assign rsp_tuser  = rsp_st_ff;

   `ART_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= DEPTH_C)
   `ART_ASSERT_NEXT(a_publish_valid, clock, reset, cmd.publish, rsp_valid_ff)
   `ART_ASSERT_NOW(a_no_read_past_count, clock, reset, do_read, issue_ff < count_ff)

endmodule

[rtl/art_ctrl.sv]
// Controller of the relocation table: sequences load, scan and result hand-off.
// Depends on art_pkg and assert_macros.svh.
`include "assert_macros.svh"

module art_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output art_pkg::art_cmd_type  cmd,
   input  art_pkg::art_stat_type stat
);
   import art_pkg::*;

   art_state_type state_ff, state_in;
   logic          accept;

   assign accept = req_tvalid && (state_ff == STATE_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         STATE_IDLE: begin
            if (req_tvalid) begin
               state_in = stat.is_lookup ? STATE_SCAN : STATE_PUBLISH;
            end
         end
         STATE_SCAN: begin
            if (stat.scan_done) begin
               state_in = STATE_PUBLISH;
            end
         end
         STATE_PUBLISH: begin
            if (stat.out_free) begin
               state_in = STATE_IDLE;
            end
         end
         default: state_in = STATE_IDLE;
      endcase
   end

   always_comb begin
      req_tready  = 1'b0;
      cmd.load    = 1'b0;
      cmd.scan    = 1'b0;
      cmd.publish = 1'b0;
      case (state_ff)
         STATE_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         STATE_SCAN: begin
            cmd.scan = 1'b1;
         end
         STATE_PUBLISH: begin
            cmd.publish = stat.out_free;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `ART_ASSERT_NEXT(a_scan_to_publish, clock, reset,
                    (state_ff == STATE_SCAN) && stat.scan_done, state_ff == STATE_PUBLISH)
   `ART_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, accept, state_ff != STATE_IDLE)

endmodule

[rtl/address_relocation_table_core.sv]
// Address relocation table: append (old, new) address pairs, then look them up by
// exact old address or by address range on either key. One item is handled at a time.
// An append goes from accept straight to the publish state, where its result moves into
// the output register. A lookup reads one stored entry per cycle from both entry
// memories, ending early on the first hit, and then goes to the publish state. The next
// request is accepted the cycle after the result moves into the output register, and that
// move waits while an earlier result is held there by rsp_tready. A finished result waits
// in the output register while the next request is accepted. Depends on art_pkg, art_ctrl
// and art_dp.
module address_relocation_table_core #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // entry_old_addr[31:0], entry_new_addr[63:32],
                                    // query_addr[95:64]
   input  logic [2:0]  req_tuser,   // action[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // result_addr[31:0]
   output logic [1:0]  rsp_tuser,   // status[1:0]
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data  // orig_entry_offset
);
   import art_pkg::*;

   art_cmd_type  cmd;
   art_stat_type stat;

   art_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   art_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

endmodule

[test/art_lookup_checker.sv]
// Watches both streams of address_relocation_table_core, predicts every answer and compares.
// Depends on art_pkg; instantiated beside the block by tb_address_relocation_table_core.
module art_lookup_checker #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [95:0] req_tdata,   // entry_old_addr[31:0], entry_new_addr[63:32],
                                    // query_addr[95:64]
   input  logic [2:0]  req_tuser,   // action[2:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // result_addr[31:0]
   input  logic [1:0]  rsp_tuser,   // status[1:0]
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data, // orig_entry_offset
   output int          mismatch_count,
   output int          outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import art_pkg::*;

   typedef struct packed {
      logic [31:0] addr;
      status_type  status;
   } reloc_answer_type;

   logic [31:0]      old_keys [TABLE_DEPTH];
   logic [31:0]      new_keys [TABLE_DEPTH];
   int unsigned      stored;
   logic [7:0]       offset_shadow;
   reloc_answer_type relocation_answers [$];
   reloc_answer_type want;

   // lowest index whose old address equals the query
   function automatic bit find_exact(input logic [31:0] q, output int idx);
      for (int i = 0; i < stored; i++) begin
         if (old_keys[i] == q) begin
            idx = i;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // first i with key[i] <= q < key[i+1], keyed on new or old addresses
   function automatic bit find_span(input bit on_new, input logic [31:0] q, output int idx);
      logic [31:0] lo;
      logic [31:0] hi;
      for (int i = 0; i + 1 < stored; i++) begin
         lo = on_new ? new_keys[i] : old_keys[i];
         hi = on_new ? new_keys[i + 1] : old_keys[i + 1];
         if (q >= lo && q < hi) begin
            idx = i;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic reloc_answer_type translate_request(input action_type act,
                                                          input logic [31:0] e_old, e_new, q);
      reloc_answer_type ans;
      int idx;
      ans.addr   = '0;
      ans.status = STAT_MISS;
      idx        = 0;
      case (act)
         ACT_APPEND: begin
            if (stored >= TABLE_DEPTH) begin
               ans.status = STAT_OVERFLOW;
            end else begin
               old_keys[stored] = e_old;
               new_keys[stored] = e_new;
               stored++;
               ans.status = STAT_OK;
            end
         end
         ACT_EXACT_NEW: begin
            if (find_exact(q, idx)) begin
               ans.addr   = new_keys[idx];
               ans.status = STAT_OK;
            end
         end
         ACT_EXACT_ORG: begin
            if (find_exact(q, idx)) begin
               ans.addr   = new_keys[idx] + {24'd0, offset_shadow};
               ans.status = STAT_OK;
            end
         end
         ACT_RANGE_O2N: begin
            if (find_span(1'b0, q, idx)) begin
               ans.addr   = new_keys[idx];
               ans.status = STAT_OK;
            end
         end
         ACT_RANGE_N2O: begin
            if (find_span(1'b1, q, idx)) begin
               ans.addr   = old_keys[idx];
               ans.status = STAT_OK;
            end
         end
         ACT_RANGE_O2O: begin
            if (find_span(1'b0, q, idx)) begin
               ans.addr   = old_keys[idx];
               ans.status = STAT_OK;
            end
         end
         default: ;
      endcase
      return ans;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         stored         = 0;
         offset_shadow  = OFFSET_RESET;
         mismatch_count = 0;
         relocation_answers.delete();
      end else begin
         if (csr_wr_en)
            offset_shadow = csr_wr_data;
         if (rsp_tvalid && rsp_tready) begin
            if (relocation_answers.size() == 0) begin
               $display("%0t: unexpected result transfer addr %h status %0d",
                        $time, rsp_tdata, rsp_tuser);
               mismatch_count++;
            end else begin
               want = relocation_answers.pop_front();
               if (rsp_tdata !== want.addr) begin
                  $display("%0t: result_addr expected %h actual %h",
                           $time, want.addr, rsp_tdata);
                  mismatch_count++;
               end
               if (rsp_tuser !== want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_tuser);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            relocation_answers.push_back(translate_request(req_tuser, req_tdata[31:0],
                                                           req_tdata[63:32], req_tdata[95:64]));
      end
      outstanding <= relocation_answers.size();
   end

endmodule

[test/tb_address_relocation_table_core.sv]
// Stimulus and verdict for address_relocation_table_core: directed corner cases, then
// random append/lookup traffic with stalls. Depends on art_pkg and art_lookup_checker.
module tb_address_relocation_table_core;
   timeunit 1ns;
   timeprecision 1ps;
   import art_pkg::*;

   localparam int TABLE_DEPTH   = 256;
   localparam int STALL_LIMIT   = 5000;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 300;
   localparam int PHASE_ITEMS   = 164;

   localparam action_type ACT_SPARE_LO = 3'd6;
   localparam action_type ACT_SPARE_HI = 3'd7;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [95:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_wr_en;
   logic [7:0]  csr_wr_data;

   int          mismatch_count;
   int          outstanding;
   int          quiet_cycles = 0;
   int          req_idle_pct = 18;
   int          rsp_idle_pct = 18;
   bit          hold_rsp = 1'b0;
   logic [31:0] placed_old [$];
   logic [31:0] placed_new [$];
   logic [31:0] next_old = 32'h0000_1000;
   logic [31:0] next_new = 32'h0000_1000;

   address_relocation_table_core #(.TABLE_DEPTH(TABLE_DEPTH)) u_top (.*);

   art_lookup_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic send_request(input action_type act, input logic [31:0] e_old, e_new, q);
      if ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {q, e_new, e_old};
      do @(posedge clock); while (!req_tready);
      if (act == ACT_APPEND && placed_old.size() < TABLE_DEPTH) begin
         placed_old.push_back(e_old);
         placed_new.push_back(e_new);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_offset(input logic [7:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic send_sorted_append();
      next_old += $urandom_range(32'h000F_FFFF, 1);
      next_new += $urandom_range(32'h000F_FFFF, 1);
      send_request(ACT_APPEND, next_old, next_new, $urandom);
   endtask

   // mostly ascending appends and lookups aimed at stored keys, some noise
   task automatic send_random_request();
      action_type  act;
      logic [31:0] e_old;
      logic [31:0] e_new;
      logic [31:0] q;
      logic [31:0] key;
      int          pick;
      int          sel;
      int          n;
      e_old = $urandom;
      e_new = $urandom;
      q     = $urandom;
      n     = placed_old.size();
      pick  = $urandom_range(99);
      if (pick < 35) begin
         sel = $urandom_range(99);
         if (sel < 85 || n == 0) begin
            send_sorted_append();
            return;
         end
         act = ACT_APPEND;
         if (sel < 96)
            e_old = placed_old[$urandom_range(n - 1)];
      end else if (pick < 39) begin
         act = pick[0] ? ACT_SPARE_HI : ACT_SPARE_LO;
      end else begin
         act = action_type'($urandom_range(int'(ACT_RANGE_O2O), int'(ACT_EXACT_NEW)));
         if (n > 0) begin
            sel = $urandom_range(n - 1);
            key = (act == ACT_RANGE_N2O) ? placed_new[sel] : placed_old[sel];
            sel = $urandom_range(99);
            if (sel < 40)
               q = key;
            else if (sel < 75)
               q = key + $urandom_range(32'h0007_FFFF, 0);
            else if (sel < 85)
               q = key - 1;
            else if (sel < 90)
               q = sel[0] ? '1 : '0;
         end
      end
      send_request(act, e_old, e_new, q);
   endtask

   // receiver: random stalls, one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = ACT_APPEND;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty table: everything misses
      send_request(ACT_EXACT_NEW, '0, '0, '0);
      send_request(ACT_EXACT_ORG, '0, '0, '1);
      send_request(ACT_RANGE_O2N, '0, '0, '0);
      send_request(ACT_RANGE_N2O, '0, '0, '0);
      send_request(ACT_RANGE_O2O, '0, '0, '1);
      send_request(ACT_SPARE_LO, $urandom, $urandom, $urandom);
      send_request(ACT_SPARE_HI, '1, '1, '1);
      // single entry: ranges still miss
      send_request(ACT_APPEND, 32'h0000_0000, 32'hFFFF_FF00, '0);
      send_request(ACT_RANGE_O2N, '0, '0, '0);
      send_request(ACT_EXACT_NEW, '0, '0, '0);
      // duplicate old key, top new address, zero new address
      send_request(ACT_APPEND, 32'h0000_0100, 32'hFFFF_FF80, '0);
      send_request(ACT_APPEND, 32'h0000_0100, 32'hFFFF_FFF0, '0);
      send_request(ACT_APPEND, 32'h0000_0180, 32'hFFFF_FFFF, '0);
      send_request(ACT_APPEND, 32'h0000_0200, 32'h0000_0000, '0);
      send_request(ACT_EXACT_NEW, '0, '0, 32'h0000_0100);
      send_request(ACT_EXACT_ORG, '0, '0, 32'h0000_0180);
      send_request(ACT_RANGE_O2N, '0, '0, 32'h0000_0000);
      send_request(ACT_RANGE_N2O, '0, '0, 32'hFFFF_FF10);
      send_request(ACT_RANGE_O2O, '0, '0, 32'h0000_01F0);
      send_request(ACT_RANGE_O2O, '0, '0, 32'h0000_0050);
      send_request(ACT_RANGE_O2N, '0, '0, 32'h0000_0200);
      send_request(ACT_EXACT_NEW, '0, '0, 32'h0000_0200);
      send_request(ACT_RANGE_N2O, '0, '0, 32'hFFFF_FFFF);
      send_request(ACT_EXACT_NEW, '0, '0, 32'h0001_2345);

      // offset extremes, with wrap of the sum
      wait_drained();
      write_offset(8'hFF);
      send_request(ACT_EXACT_ORG, '0, '0, 32'h0000_0180);
      wait_drained();
      write_offset(8'h00);
      send_request(ACT_EXACT_ORG, '0, '0, 32'h0000_0100);

      for (int phase = 0; phase < 5; phase++) begin
         wait_drained();
         case (phase)
            1:       write_offset(8'hFF);
            3:       write_offset(8'h00);
            default: write_offset(8'($urandom));
         endcase
         req_idle_pct = (phase == 1) ? 0 : 18;
         rsp_idle_pct = (phase == 1) ? 0 : 18;
         if (phase == 2)
            hold_rsp = 1'b1;
         for (int k = 0; k < PHASE_ITEMS; k++)
            send_random_request();
      end

      // fill the table, then overflow and search it full
      while (placed_old.size() < TABLE_DEPTH)
         send_sorted_append();
      send_request(ACT_APPEND, '1, '1, '0);
      send_request(ACT_APPEND, '0, '0, '1);
      send_request(ACT_EXACT_NEW, '0, '0, '1);
      send_request(ACT_EXACT_ORG, '0, '0, placed_old[TABLE_DEPTH - 1]);
      send_request(ACT_RANGE_O2O, '0, '0, placed_old[TABLE_DEPTH - 1]);
      send_request(ACT_RANGE_N2O, '0, '0, placed_new[TABLE_DEPTH - 2] + 1);

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl
rtl/art_pkg.sv
rtl/art_dp.sv
rtl/art_ctrl.sv
rtl/address_relocation_table_core.sv
test/art_lookup_checker.sv
test/tb_address_relocation_table_core.sv
